>>> src/cpproj_pkg.sv
// shared types, constants and fixed-point helpers for the camera point projection core
// no dependencies; imported by every module of the block

package cpproj_pkg;

    // pipeline depths
    localparam int DIV_BITS    = 33;
    localparam int DIST_STAGES = 11;
    localparam int PIX_STAGES  = 3;
    localparam int LATENCY     = DIV_BITS + 2 + DIST_STAGES + PIX_STAGES;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_K1     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_K2     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_K3     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_P1     = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_P2     = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_EN = 8'd7;

    localparam logic signed [35:0] Q28_ONE = 36'sh010000000;
    localparam logic signed [35:0] S32_MAX36 = 36'sh07FFFFFFF;
    localparam logic signed [35:0] S32_MIN36 = 36'shF80000000;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] pixel_u;
        logic signed [31:0] pixel_v;
        logic               depth_invalid;
        logic               saturated;
    } pixel_t;

    // normalized coordinate pair traveling between the stages
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               sat;
        logic               inv;
    } norm_t;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] k3;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
        logic               en;
    } dist_coef_t;

    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] cx;
        logic [31:0] cy;
    } cam_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } qres_t;

    // clamp a 36-bit value into signed 32 bits
    function automatic qres_t clamp36(input logic signed [35:0] v);
        qres_t r;
        begin
            if (v > S32_MAX36) begin
                r.sat = 1'b1;
                r.val = 32'sh7FFFFFFF;
            end else if (v < S32_MIN36) begin
                r.sat = 1'b1;
                r.val = 32'sh80000000;
            end else begin
                r.sat = 1'b0;
                r.val = v[31:0];
            end
            return r;
        end
    endfunction

    // q4.28 product, floor shift by 28, then clamp
    function automatic qres_t qmul(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [63:0] p;
        begin
            p = a * b;
            return clamp36(p[63:28]);
        end
    endfunction

endpackage

>>> src/cpproj_div.sv
// pipelined restoring divider: (num * 2^28) / den, truncated toward zero, clamped to s32
// depends on cpproj_pkg

module cpproj_div
    import cpproj_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] num,
    input  logic        [31:0] den,
    input  logic               tag_in,
    output logic               out_valid,
    output logic signed [31:0] quot,
    output logic               sat,
    output logic               tag
);

    logic [DIV_BITS:0]  vld_reg;
    logic [59:0]        n_reg   [0:DIV_BITS];
    logic [30:0]        d_reg   [0:DIV_BITS];
    logic [31:0]        r_reg   [0:DIV_BITS];
    logic [DIV_BITS-1:0] q_reg  [0:DIV_BITS];
    logic               neg_reg [0:DIV_BITS];
    logic               ovf_reg [0:DIV_BITS];
    logic               tag_reg [0:DIV_BITS];

    logic [31:0] mag;
    logic [59:0] n_in;
    logic        out_valid_reg;
    qres_t       res_reg;
    logic        tag_out_reg;
    qres_t       res_next;

    assign mag  = num[31] ? (~num + 32'd1) : num;
    assign n_in = {mag, 28'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= {vld_reg[DIV_BITS-1:0], in_valid};
            out_valid_reg <= vld_reg[DIV_BITS];
        end
    end

    // entry stage: magnitude, early overflow test, first partial remainder
    always_ff @(posedge clk)
    begin
        n_reg[0]   <= n_in;
        d_reg[0]   <= den[30:0];
        r_reg[0]   <= {5'd0, n_in[59:33]};
        q_reg[0]   <= '0;
        neg_reg[0] <= num[31];
        ovf_reg[0] <= ({4'd0, n_in[59:33]} >= den[30:0]);
        tag_reg[0] <= tag_in;
    end

    genvar k;
    for (k = 0; k < DIV_BITS; k++)
    begin : g_stage
        logic [32:0] t;
        logic        ge;

        always_comb
        begin
            t  = {r_reg[k], n_reg[k][DIV_BITS-1-k]};
            ge = (t >= {2'd0, d_reg[k]});
        end

        always_ff @(posedge clk)
        begin
            n_reg[k+1]   <= n_reg[k];
            d_reg[k+1]   <= d_reg[k];
            r_reg[k+1]   <= ge ? 32'(t - {2'd0, d_reg[k]}) : t[31:0];
            q_reg[k+1]   <= {q_reg[k][DIV_BITS-2:0], ge};
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
            tag_reg[k+1] <= tag_reg[k];
        end
    end

    // sign and clamp
    always_comb
    begin
        if (neg_reg[DIV_BITS])
        begin
            if (ovf_reg[DIV_BITS] || (q_reg[DIV_BITS] > 33'h080000000))
            begin
                res_next.sat = 1'b1;
                res_next.val = 32'sh80000000;
            end
            else
            begin
                res_next.sat = 1'b0;
                res_next.val = 32'(~q_reg[DIV_BITS] + 33'd1);
            end
        end
        else
        begin
            if (ovf_reg[DIV_BITS] || (q_reg[DIV_BITS] > 33'h07FFFFFFF))
            begin
                res_next.sat = 1'b1;
                res_next.val = 32'sh7FFFFFFF;
            end
            else
            begin
                res_next.sat = 1'b0;
                res_next.val = q_reg[DIV_BITS][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        tag_out_reg <= tag_reg[DIV_BITS];
    end

    assign out_valid = out_valid_reg;
    assign quot      = res_reg.val;
    assign sat       = res_reg.sat;
    assign tag       = tag_out_reg;

endmodule

>>> src/cpproj_dist.sv
// brown-conrady radial and tangential distortion, one q4.28 multiply or sum level per stage
// depends on cpproj_pkg

module cpproj_dist
    import cpproj_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  norm_t      in_pt,
    input  dist_coef_t coef,
    output logic       out_valid,
    output norm_t      out_pt
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] r2;
        logic signed [31:0] r4;
        logic signed [31:0] r6;
        logic signed [31:0] t1;
        logic signed [31:0] t2;
        logic signed [31:0] t3;
        logic signed [31:0] f;
        logic signed [31:0] xf;
        logic signed [31:0] yf;
        logic signed [31:0] xy;
        logic signed [31:0] xx;
        logic signed [31:0] yy;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic               sat;
        logic               dsat;
        logic               inv;
    } dstage_t;

    logic [DIST_STAGES-1:0] vld_reg;
    dstage_t s0;
    dstage_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;
    dstage_t s7_reg, s8_reg, s9_reg, s10_reg, s11_reg;
    dstage_t s1_next, s2_next, s3_next, s4_next, s5_next, s6_next;
    dstage_t s7_next, s8_next, s9_next, s10_next, s11_next;

    always_comb
    begin
        s0     = '0;
        s0.x   = in_pt.x;
        s0.y   = in_pt.y;
        s0.sat = in_pt.sat;
        s0.inv = in_pt.inv;
    end

    // x*x, y*y
    always_comb
    begin : st1
        qres_t ra, rb;
        ra = qmul(s0.x, s0.x);
        rb = qmul(s0.y, s0.y);
        s1_next      = s0;
        s1_next.xx   = ra.val;
        s1_next.yy   = rb.val;
        s1_next.dsat = ra.sat | rb.sat;
    end

    // r2
    always_comb
    begin : st2
        qres_t ra;
        ra = clamp36(36'(s1_reg.xx) + 36'(s1_reg.yy));
        s2_next      = s1_reg;
        s2_next.r2   = ra.val;
        s2_next.dsat = s1_reg.dsat | ra.sat;
    end

    // r4, k1*r2
    always_comb
    begin : st3
        qres_t ra, rb;
        ra = qmul(s2_reg.r2, s2_reg.r2);
        rb = qmul(coef.k1, s2_reg.r2);
        s3_next      = s2_reg;
        s3_next.r4   = ra.val;
        s3_next.t1   = rb.val;
        s3_next.dsat = s2_reg.dsat | ra.sat | rb.sat;
    end

    // r6, k2*r4
    always_comb
    begin : st4
        qres_t ra, rb;
        ra = qmul(s3_reg.r4, s3_reg.r2);
        rb = qmul(coef.k2, s3_reg.r4);
        s4_next      = s3_reg;
        s4_next.r6   = ra.val;
        s4_next.t2   = rb.val;
        s4_next.dsat = s3_reg.dsat | ra.sat | rb.sat;
    end

    // k3*r6
    always_comb
    begin : st5
        qres_t ra;
        ra = qmul(coef.k3, s4_reg.r6);
        s5_next      = s4_reg;
        s5_next.t3   = ra.val;
        s5_next.dsat = s4_reg.dsat | ra.sat;
    end

    // radial factor
    always_comb
    begin : st6
        qres_t ra;
        ra = clamp36(Q28_ONE + 36'(s5_reg.t1) + 36'(s5_reg.t2) + 36'(s5_reg.t3));
        s6_next      = s5_reg;
        s6_next.f    = ra.val;
        s6_next.dsat = s5_reg.dsat | ra.sat;
    end

    // scaled coordinates
    always_comb
    begin : st7
        qres_t ra, rb;
        ra = qmul(s6_reg.x, s6_reg.f);
        rb = qmul(s6_reg.y, s6_reg.f);
        s7_next      = s6_reg;
        s7_next.xf   = ra.val;
        s7_next.yf   = rb.val;
        s7_next.dsat = s6_reg.dsat | ra.sat | rb.sat;
    end

    // cross and square terms of the scaled coordinates
    always_comb
    begin : st8
        qres_t ra, rb, rc;
        ra = qmul(s7_reg.xf, s7_reg.yf);
        rb = qmul(s7_reg.xf, s7_reg.xf);
        rc = qmul(s7_reg.yf, s7_reg.yf);
        s8_next      = s7_reg;
        s8_next.xy   = ra.val;
        s8_next.xx   = rb.val;
        s8_next.yy   = rc.val;
        s8_next.dsat = s7_reg.dsat | ra.sat | rb.sat | rc.sat;
    end

    // r2 + 2*sq, p1*xy, p2*xy
    always_comb
    begin : st9
        qres_t ra, rb, rc, rd;
        ra = clamp36(36'(s8_reg.r2) + (36'(s8_reg.xx) <<< 1));
        rb = clamp36(36'(s8_reg.r2) + (36'(s8_reg.yy) <<< 1));
        rc = qmul(coef.p1, s8_reg.xy);
        rd = qmul(coef.p2, s8_reg.xy);
        s9_next      = s8_reg;
        s9_next.tx   = ra.val;
        s9_next.ty   = rb.val;
        s9_next.a    = rc.val;
        s9_next.b    = rd.val;
        s9_next.dsat = s8_reg.dsat | ra.sat | rb.sat | rc.sat | rd.sat;
    end

    // p2*tx, p1*ty
    always_comb
    begin : st10
        qres_t ra, rb;
        ra = qmul(coef.p2, s9_reg.tx);
        rb = qmul(coef.p1, s9_reg.ty);
        s10_next      = s9_reg;
        s10_next.c    = ra.val;
        s10_next.d    = rb.val;
        s10_next.dsat = s9_reg.dsat | ra.sat | rb.sat;
    end

    // final sums, bypass when distortion is off
    always_comb
    begin : st11
        qres_t ra, rb;
        ra = clamp36(36'(s10_reg.xf) + (36'(s10_reg.a) <<< 1) + 36'(s10_reg.c));
        rb = clamp36(36'(s10_reg.yf) + (36'(s10_reg.b) <<< 1) + 36'(s10_reg.d));
        s11_next = s10_reg;
        if (coef.en)
        begin
            s11_next.x   = ra.val;
            s11_next.y   = rb.val;
            s11_next.sat = s10_reg.sat | s10_reg.dsat | ra.sat | rb.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DIST_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        s2_reg  <= s2_next;
        s3_reg  <= s3_next;
        s4_reg  <= s4_next;
        s5_reg  <= s5_next;
        s6_reg  <= s6_next;
        s7_reg  <= s7_next;
        s8_reg  <= s8_next;
        s9_reg  <= s9_next;
        s10_reg <= s10_next;
        s11_reg <= s11_next;
    end

    assign out_valid  = vld_reg[DIST_STAGES-1];
    assign out_pt.x   = s11_reg.x;
    assign out_pt.y   = s11_reg.y;
    assign out_pt.sat = s11_reg.sat;
    assign out_pt.inv = s11_reg.inv;

endmodule

>>> src/cpproj_pix.sv
// focal scaling and principal point offset into saturated q16.16 pixels
// depends on cpproj_pkg

module cpproj_pix
    import cpproj_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  norm_t  in_pt,
    input  cam_t   cam,
    output logic   out_valid,
    output pixel_t out_px
);

    logic [PIX_STAGES-1:0] vld_reg;
    logic signed [63:0] pu_reg, pv_reg;
    logic signed [64:0] pu_next, pv_next;
    logic               sat_a_reg, inv_a_reg;
    logic signed [31:0] u_reg, v_reg;
    logic               sat_b_reg, inv_b_reg;
    pixel_t             px_reg, px_next;
    logic signed [36:0] su, sv;
    logic               cu, cv;
    logic signed [31:0] u_next, v_next;

    assign pu_next = in_pt.x * $signed({1'b0, cam.fx});
    assign pv_next = in_pt.y * $signed({1'b0, cam.fy});

    // floor shift, offset, clamp
    always_comb
    begin
        su = 37'($signed(pu_reg[63:28])) + $signed({5'd0, cam.cx});
        sv = 37'($signed(pv_reg[63:28])) + $signed({5'd0, cam.cy});
        cu = 1'b0;
        cv = 1'b0;
        u_next = su[31:0];
        v_next = sv[31:0];
        if (su > 37'sh007FFFFFFF)
        begin
            cu = 1'b1;
            u_next = 32'sh7FFFFFFF;
        end
        else if (su < -37'sh0080000000)
        begin
            cu = 1'b1;
            u_next = 32'sh80000000;
        end
        if (sv > 37'sh007FFFFFFF)
        begin
            cv = 1'b1;
            v_next = 32'sh7FFFFFFF;
        end
        else if (sv < -37'sh0080000000)
        begin
            cv = 1'b1;
            v_next = 32'sh80000000;
        end
    end

    // invalid depth forces zeros
    always_comb
    begin
        px_next.depth_invalid = inv_b_reg;
        px_next.pixel_u       = inv_b_reg ? '0 : u_reg;
        px_next.pixel_v       = inv_b_reg ? '0 : v_reg;
        px_next.saturated     = inv_b_reg ? 1'b0 : sat_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIX_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        pu_reg    <= pu_next[63:0];
        pv_reg    <= pv_next[63:0];
        sat_a_reg <= in_pt.sat;
        inv_a_reg <= in_pt.inv;
        u_reg     <= u_next;
        v_reg     <= v_next;
        sat_b_reg <= sat_a_reg | cu | cv;
        inv_b_reg <= inv_a_reg;
        px_reg    <= px_next;
    end

    assign out_valid = vld_reg[PIX_STAGES-1];
    assign out_px    = px_reg;

endmodule

>>> src/camera_point_projection_core.sv
// top level of the camera point projection core: config registers and the projection pipeline
// depends on cpproj_pkg, cpproj_div, cpproj_dist, cpproj_pix

// Pinhole projection with optional Brown-Conrady lens distortion. A request is taken
// on every clock at which start is high; busy never rises, so points can stream at one
// per clock. Each request produces exactly one result, shown on result for a single
// cycle with result_valid high. The receiver cannot stall the block, so results must be
// captured in the cycle they appear. A result passes through the depth divider (one
// quotient bit per stage, 33 stages plus entry and exit registers), the distortion
// chain (11 stages, one multiply or sum level each) and the pixel scaling (3 stages). A
// depth at or below zero yields depth_invalid with zero coordinates. Config writes
// (cfg_ready is always high) must only be issued while no request is in flight.

module camera_point_projection_core
    import cpproj_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request side
    input  logic                 start,
    output logic                 busy,
    input  point_t               point,
    // result side
    output logic                 result_valid,
    output pixel_t               result,
    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    // config registers
    logic [63:0] focal_reg;
    logic [63:0] center_reg;
    logic [31:0] k1_reg, k2_reg, k3_reg, p1_reg, p2_reg;
    logic        dist_en_reg;

    logic        req;
    logic        depth_bad;
    logic        dx_valid, dy_valid;
    logic signed [31:0] qx, qy;
    logic        sx, sy;
    logic        tag_x, tag_y;
    norm_t       div_pt;
    norm_t       dist_pt;
    logic        dist_valid;
    dist_coef_t  coef;
    cam_t        cam;

    // no back-pressure anywhere in the pipe
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign req       = start & ~busy;

    // non-positive depth is flagged at entry and carried along
    assign depth_bad = point.point_z[31] | (point.point_z == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg   <= '0;
            center_reg  <= '0;
            k1_reg      <= '0;
            k2_reg      <= '0;
            k3_reg      <= '0;
            p1_reg      <= '0;
            p2_reg      <= '0;
            dist_en_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FOCAL:   focal_reg   <= cfg_data;
                REG_CENTER:  center_reg  <= cfg_data;
                REG_K1:      k1_reg      <= cfg_data[31:0];
                REG_K2:      k2_reg      <= cfg_data[31:0];
                REG_K3:      k3_reg      <= cfg_data[31:0];
                REG_P1:      p1_reg      <= cfg_data[31:0];
                REG_P2:      p2_reg      <= cfg_data[31:0];
                REG_DIST_EN: dist_en_reg <= cfg_data[0];
                default:     ; // unknown index, write dropped
            endcase
        end
    end

    assign coef.k1 = k1_reg;
    assign coef.k2 = k2_reg;
    assign coef.k3 = k3_reg;
    assign coef.p1 = p1_reg;
    assign coef.p2 = p2_reg;
    assign coef.en = dist_en_reg;

    assign cam.fx = focal_reg[31:0];
    assign cam.fy = focal_reg[63:32];
    assign cam.cx = center_reg[31:0];
    assign cam.cy = center_reg[63:32];

    // x / z and y / z share the depth, run as two identical dividers
    cpproj_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req),
        .num       (point.point_x),
        .den       (point.point_z),
        .tag_in    (depth_bad),
        .out_valid (dx_valid),
        .quot      (qx),
        .sat       (sx),
        .tag       (tag_x)
    );

    cpproj_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req),
        .num       (point.point_y),
        .den       (point.point_z),
        .tag_in    (depth_bad),
        .out_valid (dy_valid),
        .quot      (qy),
        .sat       (sy),
        .tag       (tag_y)
    );

    // both dividers run in lockstep; the y copy's valid and depth tag match the x copy's
    assign div_pt.x   = qx;
    assign div_pt.y   = qy;
    assign div_pt.sat = sx | sy;
    assign div_pt.inv = tag_x & tag_y;

    // lens distortion, bypassed inside when disabled
    cpproj_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dx_valid & dy_valid),
        .in_pt     (div_pt),
        .coef      (coef),
        .out_valid (dist_valid),
        .out_pt    (dist_pt)
    );

    // focal scaling and principal point
    cpproj_pix u_pix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dist_valid),
        .in_pt     (dist_pt),
        .cam       (cam),
        .out_valid (result_valid),
        .out_px    (result)
    );

endmodule

>>> src/cpproj_chk.sv
// port-level checker for camera_point_projection_core, attached by bind
// depends on cpproj_pkg

module cpproj_chk
    import cpproj_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   start,
    input logic   busy,
    input point_t point,
    input logic   result_valid,
    input pixel_t result
);

    // every request is answered by a result_valid
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY result_valid)
        else $error("result missing after request");

    // bad depth gives an invalid result
    a_bad_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (point.point_z[31] || point.point_z == '0))
        |-> ##LATENCY (result_valid && result.depth_invalid))
        else $error("non-positive depth not flagged");

    // good depth never flagged
    a_good_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !point.point_z[31] && point.point_z != '0)
        |-> ##LATENCY (result_valid && !result.depth_invalid))
        else $error("positive depth flagged invalid");

    // invalid result carries zero coordinates and no saturation
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.depth_invalid)
        |-> (result.pixel_u == '0 && result.pixel_v == '0 && !result.saturated))
        else $error("invalid result has nonzero fields");

endmodule

bind camera_point_projection_core cpproj_chk u_cpproj_chk (.*);

>>> bench/camera_point_projection_core_test.sv
// testbench for the camera point projection core: streams points, predicts pixels, checks results
// depends on cpproj_pkg and camera_point_projection_core

`timescale 1ns / 100ps

module camera_point_projection_core_test;
    import cpproj_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    point_t               point;
    logic                 result_valid;
    pixel_t               result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    camera_point_projection_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .point        (point),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    localparam int WATCHDOG_LIMIT = 2000;

    // camera settings as the predictor sees them
    logic [63:0]        cam_focal;
    logic [63:0]        cam_center;
    logic signed [31:0] coef_k1, coef_k2, coef_k3, coef_p1, coef_p2;
    logic               lens_on;

    pixel_t pending_pixels[$];
    int     fail_count;
    int     points_sent;
    int     pixels_seen;
    int     idle_cycles;
    int     sat_seen;
    int     invalid_seen;
    bit     timed_out;

    // free-running clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ---------------------------------------------------------------
    // predictor arithmetic, all in 64-bit signed math
    // ---------------------------------------------------------------
    function automatic longint sat32(input longint v, inout bit s);
        if (v > 64'sd2147483647)
        begin
            s = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            s = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // q4.28 product with floor shift
    function automatic longint fmul(input longint a, input longint b, inout bit s);
        return sat32((a * b) >>> 28, s);
    endfunction

    // q4.28 normalized coordinate to q16.16 pixel
    function automatic longint scale_pixel(input longint n, input logic [31:0] focal,
                                           input logic [31:0] center, inout bit s);
        longint prod;
        prod = n * longint'({32'd0, focal});
        return sat32((prod >>> 28) + longint'({32'd0, center}), s);
    endfunction

    function automatic pixel_t project_point(input point_t p);
        pixel_t r;
        bit     s;
        longint x, y, z, r2, r4, r6, f, xf, yf, xy, tx, ty;
        longint u, v;
        s = 1'b0;
        r = '0;
        z = longint'(p.point_z);
        if (z <= 0)
        begin
            r.depth_invalid = 1'b1;
            return r;
        end
        // division truncates toward zero, as the operator does
        x = sat32((longint'(p.point_x) * 64'sd268435456) / z, s);
        y = sat32((longint'(p.point_y) * 64'sd268435456) / z, s);
        if (lens_on)
        begin
            r2 = sat32(fmul(x, x, s) + fmul(y, y, s), s);
            r4 = fmul(r2, r2, s);
            r6 = fmul(r4, r2, s);
            f  = sat32(64'sd268435456 + fmul(coef_k1, r2, s) + fmul(coef_k2, r4, s)
                       + fmul(coef_k3, r6, s), s);
            xf = fmul(x, f, s);
            yf = fmul(y, f, s);
            xy = fmul(xf, yf, s);
            tx = sat32(r2 + 2 * fmul(xf, xf, s), s);
            ty = sat32(r2 + 2 * fmul(yf, yf, s), s);
            x  = sat32(xf + 2 * fmul(coef_p1, xy, s) + fmul(coef_p2, tx, s), s);
            y  = sat32(yf + 2 * fmul(coef_p2, xy, s) + fmul(coef_p1, ty, s), s);
        end
        u = scale_pixel(x, cam_focal[31:0], cam_center[31:0], s);
        v = scale_pixel(y, cam_focal[63:32], cam_center[63:32], s);
        r.pixel_u   = u[31:0];
        r.pixel_v   = v[31:0];
        r.saturated = s;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // shared request and config tasks
    // ---------------------------------------------------------------
    task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                              input logic signed [31:0] pz);
        point_t p;
        p.point_x = px;
        p.point_y = py;
        p.point_z = pz;
        start <= 1'b1;
        point <= p;
        // hold until the request is taken
        do
            @(posedge clk);
        while (busy);
        pending_pixels.push_back(project_point(p));
        points_sent++;
    endtask

    task automatic end_burst();
        start <= 1'b0;
    endtask

    // random gap between bursts, lowering start first
    task automatic random_gap();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // wait until all predicted pixels have come back, then let the pipe drain
    task automatic drain();
        wait (pending_pixels.size() == 0 || timed_out);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        // waiting with cfg_valid low keeps back-to-back writes apart
        @(posedge clk);
        case (idx)
            REG_FOCAL:   cam_focal  = data;
            REG_CENTER:  cam_center = data;
            REG_K1:      coef_k1    = data[31:0];
            REG_K2:      coef_k2    = data[31:0];
            REG_K3:      coef_k3    = data[31:0];
            REG_P1:      coef_p1    = data[31:0];
            REG_P2:      coef_p2    = data[31:0];
            REG_DIST_EN: lens_on    = data[0];
            default: ;
        endcase
    endtask

    task automatic write_lens(input logic [31:0] k1, input logic [31:0] k2,
                              input logic [31:0] k3, input logic [31:0] p1,
                              input logic [31:0] p2, input logic [63:0] en);
        write_reg(REG_K1, {$urandom, k1});
        write_reg(REG_K2, {$urandom, k2});
        write_reg(REG_K3, {$urandom, k3});
        write_reg(REG_P1, {$urandom, p1});
        write_reg(REG_P2, {$urandom, p2});
        write_reg(REG_DIST_EN, en);
    endtask

    // random point, mostly in front of the camera with sane ratios
    task automatic send_random_point();
        logic signed [31:0] px, py, pz;
        case ($urandom_range(0, 9))
            0:       pz = $urandom;
            1:       pz = -$signed($urandom_range(0, 1000));
            default: pz = $urandom_range(1 << 14, 1 << 22);
        endcase
        if ($urandom_range(0, 5) == 0)
        begin
            px = $urandom;
            py = $urandom;
        end
        else
        begin
            px = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            py = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        end
        send_point(px, py, pz);
    endtask

    // ---------------------------------------------------------------
    // result checker: result_valid is a one-cycle strobe, no backpressure
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && result_valid)
        begin
            pixels_seen++;
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                fail_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (result.pixel_u !== want.pixel_u)
                begin
                    $display("%0t: pixel_u expected %h actual %h", $time, want.pixel_u,
                             result.pixel_u);
                    fail_count++;
                end
                if (result.pixel_v !== want.pixel_v)
                begin
                    $display("%0t: pixel_v expected %h actual %h", $time, want.pixel_v,
                             result.pixel_v);
                    fail_count++;
                end
                if (result.depth_invalid !== want.depth_invalid)
                begin
                    $display("%0t: depth_invalid expected %b actual %b", $time,
                             want.depth_invalid, result.depth_invalid);
                    fail_count++;
                end
                if (result.saturated !== want.saturated)
                begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.saturated, result.saturated);
                    fail_count++;
                end
                sat_seen     += want.saturated;
                invalid_seen += want.depth_invalid;
            end
        end
    end

    // watchdog: cycles with no request taken, no config write and no result seen
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out <= 1'b1;
            $display("watchdog expired at %0t", $time);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // plain pinhole at reset defaults, then with a real camera
    task automatic test_pinhole();
        send_point(32'sd65536, 32'sd65536, 32'sd65536);
        end_burst();
        drain();
        write_reg(REG_FOCAL, {32'd600 << 16, 32'd640 << 16});
        write_reg(REG_CENTER, {32'd240 << 16, 32'd320 << 16});
        send_point(32'sd65536, -32'sd65536, 32'sd131072);
        send_point(32'sh7FFFFFFF, 32'sh80000000, 32'sd1);          // divide clamp
        send_point(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_point(32'sd0, 32'sd0, 32'sh7FFFFFFF);
        send_point(32'sd1, -32'sd1, 32'sd1);
        end_burst();
        drain();
    endtask

    // depth at or below zero
    task automatic test_bad_depth();
        send_point(32'sd65536, 32'sd65536, 32'sd0);
        send_point(32'sd65536, 32'sd65536, -32'sd1);
        send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
        end_burst();
        drain();
    endtask

    // focal and center extremes overflow the output
    task automatic test_output_clamp();
        write_reg(REG_FOCAL, 64'hFFFFFFFF_FFFFFFFF);
        write_reg(REG_CENTER, 64'hFFFFFFFF_FFFFFFFF);
        send_point(32'sd65536, -32'sd65536, 32'sd65536);
        send_point(32'sd0, 32'sd0, 32'sd65536);
        send_point(32'sh80000000, 32'sh80000000, 32'sd65536);
        end_burst();
        drain();
        write_reg(REG_CENTER, 64'd0);
        send_point(-32'sd65536, -32'sd65536, 32'sd65536);
        end_burst();
        drain();
    endtask

    // lens model with moderate and extreme coefficients
    task automatic test_distortion();
        write_reg(REG_FOCAL, {32'd500 << 16, 32'd500 << 16});
        write_reg(REG_CENTER, {32'd240 << 16, 32'd320 << 16});
        write_lens(32'hFE000000, 32'h00400000, 32'hFFF00000, 32'h00080000, 32'hFFF80000,
                   64'hFFFF_FFFF_FFFF_FFFF);   // only bit 0 should matter
        send_point(32'sd32768, 32'sd16384, 32'sd65536);
        send_point(-32'sd65536, 32'sd65536, 32'sd65536);
        send_point(32'sd300000, -32'sd300000, 32'sd65536);
        end_burst();
        drain();
        write_lens(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                   64'd1);
        send_point(32'sd65536, 32'sd65536, 32'sd65536);
        send_point(32'sh7FFFFFFF, 32'sh80000000, 32'sd1);
        end_burst();
        drain();
        // even value: bit 0 clear turns the lens model off
        write_reg(REG_DIST_EN, 64'd2);
        send_point(32'sd65536, 32'sd65536, 32'sd65536);
        end_burst();
        drain();
        // out-of-range index is dropped
        write_reg(8'd8, 64'd1);
        write_reg(8'hFF, 64'd1);
        send_point(32'sd65536, 32'sd65536, 32'sd65536);
        end_burst();
        drain();
    endtask

    // random points in bursts; settings changed between phases
    task automatic test_random_stream();
        for (int phase = 0; phase < 10; phase++)
        begin
            write_reg(REG_FOCAL, phase == 9 ? 64'hFFFFFFFF_FFFFFFFF :
                      {$urandom_range(1, 2000) << 16, $urandom_range(1, 2000) << 16});
            write_reg(REG_CENTER, phase == 8 ? 64'hFFFFFFFF_FFFFFFFF : {$urandom, $urandom});
            if (phase % 3 == 2)
                write_lens($urandom, $urandom, $urandom, $urandom, $urandom, 64'd1);
            else
                write_lens($signed($urandom_range(0, 1 << 26)) - (1 << 25),
                           $signed($urandom_range(0, 1 << 24)) - (1 << 23),
                           $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                           $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                           $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                           {$urandom, $urandom});
            for (int i = 0; i < 53; i++)
            begin
                // back-to-back stretch in odd phases
                if (phase % 2 == 0)
                    random_gap();
                send_random_point();
            end
            end_burst();
            drain();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        point       = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cam_focal   = '0;
        cam_center  = '0;
        coef_k1     = '0;
        coef_k2     = '0;
        coef_k3     = '0;
        coef_p1     = '0;
        coef_p2     = '0;
        lens_on     = 1'b0;
        fail_count  = 0;
        points_sent = 0;
        pixels_seen = 0;
        idle_cycles = 0;
        sat_seen    = 0;
        invalid_seen = 0;
        timed_out   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pinhole();
        test_bad_depth();
        test_output_clamp();
        test_distortion();
        test_random_stream();

        $display("sent %0d points, checked %0d pixels (%0d saturated, %0d bad depth)",
                 points_sent, pixels_seen, sat_seen, invalid_seen);
        $display("covered pinhole, lens model, clamp and register extremes");
        if (fail_count == 0 && pending_pixels.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/cpproj_pkg.sv
src/cpproj_div.sv
src/cpproj_dist.sv
src/cpproj_pix.sv
src/camera_point_projection_core.sv
src/cpproj_chk.sv
bench/camera_point_projection_core_test.sv
